>>> rtl/button_click_hold_detector_top_macros.svh
// ---------------------------------------------------------------------------
// Button click and hold detector: assertion macros
// Shared property shorthands for the checker of the detector.
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_DETECTOR_TOP_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bchd_pkg.sv
// ---------------------------------------------------------------------------
// Button click and hold detector package
// Request and result types, configuration fields, register indexes and
// button mode codes.
// ---------------------------------------------------------------------------
package bchd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] REG_HOLD       = 3'd1;
    localparam logic [2:0] REG_GAP        = 3'd2;
    localparam logic [2:0] REG_LEVEL      = 3'd3;
    localparam logic [2:0] REG_POLARITY   = 3'd4;

    // Button mode codes.
    localparam logic [1:0] MODE_AWAIT    = 2'd0;
    localparam logic [1:0] MODE_PRESSED  = 2'd1;
    localparam logic [1:0] MODE_HELD     = 2'd2;
    localparam logic [1:0] MODE_RELEASED = 2'd3;

    localparam logic [3:0] MAX_CLICKS = 4'd15;

    // Reset values of the configuration registers.
    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [15:0] HOLD_RST     = 16'd500;
    localparam logic [15:0] GAP_RST      = 16'd300;

    typedef struct packed {
        logic [15:0] now_ms;
        logic        pin_level;
    } in_t;

    typedef struct packed {
        logic       clicked;
        logic       held_start;
        logic       holding;
        logic       released;
        logic [3:0] series_clicks;
        logic [3:0] clicks_before_held;
        logic [3:0] clicks_before_hold;
        logic [3:0] click_count;
        logic       is_pressed;
    } out_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] hold_ms;
        logic [15:0] release_gap_ms;
        logic        level_sense;
        logic        closed_polarity;
    } cfg_t;

endpackage

>>> rtl/bchd_core.sv
// ---------------------------------------------------------------------------
// Button click and hold detector core
// Debounce and click/hold state machine. Computes the result of one request
// and updates its state when the request is accepted.
// ---------------------------------------------------------------------------
module bchd_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  bchd_pkg::cfg_t cfg,
    input  bchd_pkg::in_t  item,
    output bchd_pkg::out_t result
);
    import bchd_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic        pressed_reg, pressed_next;
    logic        prev_reg, prev_next;
    logic [15:0] change_reg, change_next;
    logic [15:0] phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [3:0]  held_prior_reg, held_prior_next;
    logic [3:0]  hold_prior_reg, hold_prior_next;

    logic        reading;
    logic        run;
    logic [15:0] debounce_age;
    logic [15:0] phase_age;
    logic [3:0]  count_less;

    // Reading and debounce age use the stamp as it stands after this request.
    assign reading      = (item.pin_level == cfg.level_sense);
    assign change_next  = (reading != prev_reg) ? item.now_ms : change_reg;
    assign debounce_age = item.now_ms - change_next;
    assign run          = (debounce_age > cfg.debounce_ms);
    assign phase_age    = item.now_ms - phase_reg;
    assign count_less   = count_reg - 4'd1;
    assign prev_next    = reading;

    // Click and hold state machine.
    always_comb
    begin
        mode_next       = mode_reg;
        pressed_next    = pressed_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        held_prior_next = held_prior_reg;
        hold_prior_next = hold_prior_reg;
        result          = '0;
        if (run)
        begin
            pressed_next = reading ^ cfg.closed_polarity;
            if (pressed_next)
            begin
                case (mode_reg)
                    MODE_AWAIT:
                    begin
                        mode_next      = MODE_PRESSED;
                        phase_next     = item.now_ms;
                        count_next     = 4'd1;
                        result.clicked = 1'b1;
                    end
                    MODE_PRESSED:
                    begin
                        if (phase_age >= cfg.hold_ms)
                        begin
                            mode_next         = MODE_HELD;
                            phase_next        = item.now_ms;
                            result.held_start = 1'b1;
                            held_prior_next   = count_less;
                        end
                    end
                    MODE_HELD:
                    begin
                        result.holding  = 1'b1;
                        hold_prior_next = count_less;
                    end
                    default:
                    begin
                        mode_next      = MODE_PRESSED;
                        phase_next     = item.now_ms;
                        count_next     = count_reg + 4'd1;
                        result.clicked = 1'b1;
                    end
                endcase
            end
            else
            begin
                case (mode_reg)
                    MODE_PRESSED:
                    begin
                        // A full count closes the series right at release.
                        if (count_reg == MAX_CLICKS)
                        begin
                            mode_next            = MODE_AWAIT;
                            result.series_clicks = count_reg;
                            count_next           = 4'd0;
                        end
                        else
                        begin
                            mode_next = MODE_RELEASED;
                        end
                        phase_next      = item.now_ms;
                        result.released = 1'b1;
                    end
                    MODE_HELD:
                    begin
                        mode_next       = MODE_AWAIT;
                        phase_next      = item.now_ms;
                        count_next      = 4'd0;
                        result.released = 1'b1;
                    end
                    MODE_RELEASED:
                    begin
                        if (phase_age >= cfg.release_gap_ms)
                        begin
                            mode_next            = MODE_AWAIT;
                            phase_next           = item.now_ms;
                            result.series_clicks = count_reg;
                            count_next           = 4'd0;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
        result.clicks_before_held = held_prior_next;
        result.clicks_before_hold = hold_prior_next;
        result.click_count        = count_next;
        result.is_pressed         = pressed_next;
    end

    // State registers advance only on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_AWAIT;
            pressed_reg    <= 1'b0;
            prev_reg       <= 1'b0;
            change_reg     <= '0;
            phase_reg      <= '0;
            count_reg      <= '0;
            held_prior_reg <= '0;
            hold_prior_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            pressed_reg    <= pressed_next;
            prev_reg       <= prev_next;
            change_reg     <= change_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            held_prior_reg <= held_prior_next;
            hold_prior_reg <= hold_prior_next;
        end
    end

endmodule

>>> rtl/button_click_hold_detector_top.sv
// ---------------------------------------------------------------------------
// Button click and hold detector, top level
// Debounces a sampled button pin and reports clicks, click series and holds.
// ---------------------------------------------------------------------------
// Each request (a millisecond time stamp and a pin sample) gives exactly one
// result, which is registered into the output register when the request
// is accepted. A new request is taken in every cycle; the only thing that
// holds the input back is a full output register whose result is stalled,
// so in_stall follows out_stall while out_valid is high. Configuration
// registers are written through cfg_we, cfg_index and cfg_data and should
// only change while no request is in flight.
module button_click_hold_detector_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bchd_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output bchd_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    import bchd_pkg::*;

    cfg_t cfg_reg;
    logic out_valid_reg;
    out_t out_data_reg;
    out_t result;
    logic accept;

    // Input is held off only while a finished result waits downstream.
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
            cfg_reg.hold_ms         <= HOLD_RST;
            cfg_reg.release_gap_ms  <= GAP_RST;
            cfg_reg.level_sense     <= 1'b0;
            cfg_reg.closed_polarity <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_ms     <= cfg_data;
                REG_HOLD:     cfg_reg.hold_ms         <= cfg_data;
                REG_GAP:      cfg_reg.release_gap_ms  <= cfg_data;
                REG_LEVEL:    cfg_reg.level_sense     <= cfg_data[0];
                REG_POLARITY: cfg_reg.closed_polarity <= cfg_data[0];
                default:      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Debounce and click state machine.
    bchd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cfg    (cfg_reg),
        .item   (in_data),
        .result (result)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule

>>> rtl/bchd_checker.sv
// ---------------------------------------------------------------------------
// Button click and hold detector checker
// Port-level assertions on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "button_click_hold_detector_top_macros.svh"

module bchd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input bchd_pkg::out_t out_data
);
    import bchd_pkg::*;

    // A stalled result stays put.
    `BCHD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // A click starts a press with a nonzero count.
    `BCHD_ASSERT_IMP(a_click, clk, rst_n, out_valid && out_data.clicked, out_data.is_pressed && (out_data.click_count != 4'd0), "click without press or count")

    // A release leaves the button up.
    `BCHD_ASSERT_IMP(a_release, clk, rst_n, out_valid && out_data.released, !out_data.is_pressed && !out_data.clicked, "release while pressed")

    // A finished series clears the count.
    `BCHD_ASSERT_IMP(a_series, clk, rst_n, out_valid && (out_data.series_clicks != 4'd0), (out_data.click_count == 4'd0) && !out_data.is_pressed, "series end left count")

    // Holding and hold start need the button down and exclude a new click.
    `BCHD_ASSERT_IMP(a_hold, clk, rst_n, out_valid && (out_data.holding || out_data.held_start), out_data.is_pressed && !out_data.clicked && !out_data.released, "hold without press")

endmodule

bind button_click_hold_detector_top bchd_checker u_bchd_checker (.*);

>>> dv/button_click_hold_detector_top_test.sv
// ---------------------------------------------------------------------------
// Button click and hold detector regression
// Drives time-stamped pin samples into the detector, predicts untyped results
// with an in-bench model of the debounce and click/hold state machine, and
// compares each returned result field by field under varied idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module button_click_hold_detector_top_test;

    import bchd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_COUNT = 10;
    localparam int PHASE_ITEMS = 87;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DIR_ROWS = 23;
    localparam int MAX_SEG_MS = 65000;

    // Index past the last register; writes to it must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        bit   known;
        out_t want;
    } pinned_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Shadow configuration, starting at the reset values.
    logic [15:0] cfg_debounce = DEBOUNCE_RST;
    logic [15:0] cfg_hold = HOLD_RST;
    logic [15:0] cfg_gap = GAP_RST;
    logic        cfg_level = 1'b0;
    logic        cfg_polarity = 1'b0;

    // Shadow detector state.
    logic [1:0]  btn_mode = MODE_AWAIT;
    logic        pressed_now = 1'b0;
    logic        last_reading = 1'b0;
    logic [15:0] change_stamp = '0;
    logic [15:0] phase_stamp = '0;
    logic [3:0]  click_cnt = '0;
    logic [3:0]  held_prior = '0;
    logic [3:0]  hold_prior = '0;

    out_t        result_q[$];
    pinned_t     pinned_q[$];
    int          err_count = 0;
    int          items_sent = 0;
    int          phase_end = 0;
    int          in_idle_pct = 0;
    int          out_stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [15:0] tb_now = '0;

    // Directed rows: time, pin, typed flag, then clicked, held_start, holding,
    // released, series, before_held, before_hold, count, pressed.
    // Default wiring: pin low means pressed.
    int dir_tab [DIR_ROWS][12] = '{
        '{0,     1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // first sample after reset
        '{65535, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // top of time range, idle
        '{100,   0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // press seen, debounce running
        '{151,   0, 1, 1, 0, 0, 0, 0, 0, 0, 1, 1},   // debounce met: first click
        '{200,   1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // bounce
        '{220,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{300,   1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{351,   1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // release into gap
        '{400,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{451,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // second click
        '{460,   1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{511,   1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{811,   1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // gap reached: series of two
        '{900,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{951,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1451,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // hold time reached
        '{1460,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // holding
        '{1500,  1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1551,  1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // release from held
        '{65500, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{20,    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},   // debounce across time wrap
        '{40,    1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{91,    1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    button_click_hold_detector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advances the shadow detector by one sample and returns its result.
    function automatic out_t detector_step(in_t req);
        out_t        res;
        logic        reading;
        logic [15:0] since_change;
        logic [15:0] since_phase;
        res = '0;
        reading = (req.pin_level == cfg_level);
        if (reading != last_reading)
            change_stamp = req.now_ms;
        since_change = req.now_ms - change_stamp;
        since_phase = req.now_ms - phase_stamp;
        if (since_change > cfg_debounce)
        begin
            pressed_now = reading ^ cfg_polarity;
            if (pressed_now)
            begin
                case (btn_mode)
                    MODE_AWAIT:
                    begin
                        btn_mode = MODE_PRESSED;
                        phase_stamp = req.now_ms;
                        click_cnt = 4'd1;
                        res.clicked = 1'b1;
                    end
                    MODE_PRESSED:
                    begin
                        if (since_phase >= cfg_hold)
                        begin
                            btn_mode = MODE_HELD;
                            phase_stamp = req.now_ms;
                            res.held_start = 1'b1;
                            held_prior = click_cnt - 4'd1;
                        end
                    end
                    MODE_HELD:
                    begin
                        res.holding = 1'b1;
                        hold_prior = click_cnt - 4'd1;
                    end
                    default:
                    begin
                        btn_mode = MODE_PRESSED;
                        phase_stamp = req.now_ms;
                        click_cnt = click_cnt + 4'd1;
                        res.clicked = 1'b1;
                    end
                endcase
            end
            else
            begin
                case (btn_mode)
                    MODE_PRESSED:
                    begin
                        // At the click ceiling the series closes on release.
                        if (click_cnt == MAX_CLICKS)
                        begin
                            btn_mode = MODE_AWAIT;
                            res.series_clicks = click_cnt;
                            click_cnt = '0;
                        end
                        else
                            btn_mode = MODE_RELEASED;
                        phase_stamp = req.now_ms;
                        res.released = 1'b1;
                    end
                    MODE_HELD:
                    begin
                        btn_mode = MODE_AWAIT;
                        phase_stamp = req.now_ms;
                        click_cnt = '0;
                        res.released = 1'b1;
                    end
                    MODE_RELEASED:
                    begin
                        if (since_phase >= cfg_gap)
                        begin
                            btn_mode = MODE_AWAIT;
                            phase_stamp = req.now_ms;
                            res.series_clicks = click_cnt;
                            click_cnt = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        last_reading = reading;
        res.clicks_before_held = held_prior;
        res.clicks_before_hold = hold_prior;
        res.click_count = click_cnt;
        res.is_pressed = pressed_now;
        return res;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Scoreboard: retire returned results, then predict newly taken requests.
    always @(posedge clk)
    begin : scoreboard
        out_t    want;
        out_t    pred;
        pinned_t pin_e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result returned with no request pending");
                    err_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("clicked", want.clicked, out_data.clicked);
                    check_field("held_start", want.held_start, out_data.held_start);
                    check_field("holding", want.holding, out_data.holding);
                    check_field("released", want.released, out_data.released);
                    check_field("series_clicks", want.series_clicks,
                                out_data.series_clicks);
                    check_field("clicks_before_held", want.clicks_before_held,
                                out_data.clicks_before_held);
                    check_field("clicks_before_hold", want.clicks_before_hold,
                                out_data.clicks_before_hold);
                    check_field("click_count", want.click_count, out_data.click_count);
                    check_field("is_pressed", want.is_pressed, out_data.is_pressed);
                end
            end
            if (in_valid && !in_stall)
            begin
                pred = detector_step(in_data);
                pin_e = pinned_q.pop_front();
                result_q.push_back(pin_e.known ? pin_e.want : pred);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request from the
    // stimulus thread.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Run limit.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("button_click_hold_detector_top regression: fail");
        $finish;
    end

    // Offers one request, with random idle cycles ahead of it, and returns
    // once it has been taken.
    task automatic send_req(logic [15:0] t, logic pin, bit known, out_t want);
        in_t     req;
        pinned_t pin_e;
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        req.now_ms = t;
        req.pin_level = pin;
        pin_e.known = known;
        pin_e.want = want;
        pinned_q.push_back(pin_e);
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Stops offering and waits until every pending result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DEBOUNCE: cfg_debounce = val;
            REG_HOLD:     cfg_hold = val;
            REG_GAP:      cfg_gap = val;
            REG_LEVEL:    cfg_level = val[0];
            REG_POLARITY: cfg_polarity = val[0];
            default:      ;
        endcase
    endtask

    // One-bit registers get random upper bits, which must be masked off.
    task automatic write_all(int deb, int hold, int gap, bit lvl, bit pol);
        write_cfg(REG_DEBOUNCE, 16'(deb));
        write_cfg(REG_HOLD, 16'(hold));
        write_cfg(REG_GAP, 16'(gap));
        write_cfg(REG_LEVEL, {15'($urandom), lvl});
        write_cfg(REG_POLARITY, {15'($urandom), pol});
    endtask

    function automatic int cap_ms(int ms);
        return (ms > MAX_SEG_MS) ? MAX_SEG_MS : ms;
    endfunction

    // Holds the button in one state for dur ms, sometimes with contact bounce
    // at the start. Stops early once the phase has sent its share of requests.
    task automatic drive_level(bit pressed, int dur);
        int   spent;
        int   step;
        int   step_max;
        logic pin;
        spent = 0;
        step_max = (dur / 3 > 1) ? dur / 3 : 1;
        pin = ((pressed ^ cfg_polarity) != 0) ? cfg_level : ~cfg_level;
        if (items_sent < phase_end && $urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                send_req(tb_now, ~pin, 1'b0, '0);
                tb_now += 16'($urandom_range(0, 3));
            end
        end
        while (spent <= dur && items_sent < phase_end)
        begin
            send_req(tb_now, pin, 1'b0, '0);
            step = $urandom_range(1, step_max);
            tb_now += 16'(step);
            spent += step;
        end
    endtask

    // A well-formed click series: short presses, occasionally a hold, short
    // gaps between clicks and a long gap at the end. Some series run up to
    // and past the click ceiling.
    task automatic click_series();
        int deb;
        int hold;
        int gap;
        int clicks;
        deb = cfg_debounce;
        hold = cfg_hold;
        gap = cfg_gap;
        clicks = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 4);
        for (int i = 0; i < clicks; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                drive_level(1'b1, cap_ms(deb + hold + $urandom_range(1, hold / 2 + 10)));
            else
                drive_level(1'b1, cap_ms(deb + 1 + $urandom_range(0, hold / 2)));
            if (i == clicks - 1)
                drive_level(1'b0, cap_ms(deb + gap + $urandom_range(1, gap / 2 + 10)));
            else
                drive_level(1'b0, cap_ms(deb + 1 + $urandom_range(0, gap / 2)));
        end
    endtask

    // Random pin levels with small time steps or arbitrary time jumps.
    task automatic pin_noise();
        repeat ($urandom_range(3, 10))
        begin
            if ($urandom_range(0, 3) == 0)
                tb_now = 16'($urandom);
            else
                tb_now += 16'($urandom_range(0, 2 * int'(cfg_debounce) + 5));
            send_req(tb_now, 1'($urandom), 1'b0, '0);
        end
    endtask

    // Stimulus thread.
    initial
    begin
        out_t want;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk under the reset configuration.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            want = '0;
            want.clicked = dir_tab[r][3];
            want.held_start = dir_tab[r][4];
            want.holding = dir_tab[r][5];
            want.released = dir_tab[r][6];
            want.series_clicks = 4'(dir_tab[r][7]);
            want.clicks_before_held = 4'(dir_tab[r][8]);
            want.clicks_before_hold = 4'(dir_tab[r][9]);
            want.click_count = 4'(dir_tab[r][10]);
            want.is_pressed = dir_tab[r][11];
            send_req(16'(dir_tab[r][0]), 1'(dir_tab[r][1]), dir_tab[r][2] != 0, want);
        end
        drain();
        tb_now = 16'd100;

        // Random phases, each under its own configuration and idling mix.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    write_cfg(REG_UNUSED, 16'($urandom));
                    write_all(50, 500, 300, 1'b1, 1'b0);
                end
                1: write_all(0, 0, 0, 1'b0, 1'b1);
                2: write_all(65535, 65535, 65535, 1'b1, 1'b1);
                3: write_all(10, 100, 60, 1'b0, 1'b0);
                4: write_all(0, 65535, 0, 1'b1, 1'b0);
                7: write_all(2, 2000, 65535, 1'b0, 1'b1);
                default:
                    write_all($urandom_range(0, 40), $urandom_range(20, 400),
                              $urandom_range(10, 250), 1'($urandom), 1'($urandom));
            endcase
            case (ph % 4)
                0:
                begin
                    in_idle_pct = 0;
                    out_stall_pct <= 0;
                end
                1:
                begin
                    in_idle_pct = 55;
                    out_stall_pct <= 0;
                end
                2:
                begin
                    in_idle_pct = 0;
                    out_stall_pct <= 55;
                end
                default:
                begin
                    in_idle_pct = 12;
                    out_stall_pct <= 12;
                end
            endcase
            // Back up the block with a long result hold-off.
            if (ph == 3)
                hold_req <= hold_req + 1;
            phase_end = items_sent + ((ph == 2) ? 40 : PHASE_ITEMS);
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 2)
                    pin_noise();
                else
                    click_series();
            end
            drain();
        end

        if (err_count == 0)
            $display("button_click_hold_detector_top regression: pass");
        else
            $display("button_click_hold_detector_top regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bchd_pkg.sv
rtl/bchd_core.sv
rtl/button_click_hold_detector_top.sv
rtl/bchd_checker.sv
dv/button_click_hold_detector_top_test.sv
